>>> rtl/rqi_pkg.sv
// Package for the ray/quad intersection block: config types and register indexes.
`default_nettype none

package rqi_pkg;

  // Width of the result distance and of each limit register.
  localparam int DIST_BITS = 32;

  // Width of the configuration register index.
  localparam int CFG_IDX_BITS = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_DET_FIRST  = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DET_SECOND = 4'd1;

  // Determinant limits for the two triangle tests.
  typedef struct packed {
    logic [DIST_BITS-1:0] first;
    logic [DIST_BITS-1:0] second;
  } lim_t;

endpackage

`default_nettype wire

>>> rtl/rqi_geom.sv
// Geometry front end: edge vectors, cross products, dot products (four stages).
`default_nettype none

module rqi_geom #(
  parameter int COORD_BITS = 20
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_BITS-1:0]   origin_x,
  input  wire logic signed [COORD_BITS-1:0]   origin_y,
  input  wire logic signed [COORD_BITS-1:0]   origin_z,
  input  wire logic signed [COORD_BITS-1:0]   dir_x,
  input  wire logic signed [COORD_BITS-1:0]   dir_y,
  input  wire logic signed [COORD_BITS-1:0]   dir_z,
  input  wire logic [3*COORD_BITS-1:0]        corner_a,
  input  wire logic [3*COORD_BITS-1:0]        corner_b,
  input  wire logic [3*COORD_BITS-1:0]        corner_c,
  input  wire logic [3*COORD_BITS-1:0]        corner_d,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [3*COORD_BITS+5:0] dt,
  output logic signed [3*COORD_BITS+5:0] na,
  output logic signed [3*COORD_BITS+5:0] nb,
  output logic signed [3*COORD_BITS+5:0] nt,
  output logic signed [3*COORD_BITS+5:0] dt2,
  output logic signed [3*COORD_BITS+5:0] na2,
  output logic signed [3*COORD_BITS+5:0] nb2
);

  localparam int C  = COORD_BITS;
  localparam int E  = C + 1;
  localparam int X  = 2 * C + 3;
  localparam int PW = E + X;
  localparam int N  = 4;

  // Stage handshake: a stage loads when it is empty or its successor moves.
  logic [N-1:0] v;
  logic [N-1:0] vin;
  logic [N:0]   rdy;
  logic [N-1:0] ld;

  assign rdy[N] = out_ready;
  assign vin    = {v[N-2:0], in_valid};

  for (genvar i = 0; i < N; i++) begin : g_hs
    assign rdy[i] = !v[i] || rdy[i+1];
    assign ld[i]  = vin[i] && rdy[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (rdy[i]) begin
          v[i] <= vin[i];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[N-1];

  // Ray components as arrays.
  logic signed [C-1:0] org [3];
  logic signed [C-1:0] dir [3];

  always_comb begin
    org[0] = origin_x;
    org[1] = origin_y;
    org[2] = origin_z;
    dir[0] = dir_x;
    dir[1] = dir_y;
    dir[2] = dir_z;
  end

  // Stage 1: edge and offset vectors for both triangles.
  logic signed [E-1:0] ab1 [3];
  logic signed [E-1:0] ad1 [3];
  logic signed [E-1:0] tv1 [3];
  logic signed [E-1:0] cd1 [3];
  logic signed [E-1:0] cb1 [3];
  logic signed [E-1:0] tw1 [3];
  logic signed [E-1:0] dr1 [3];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int j = 0; j < 3; j++) begin
        ab1[j] <= $signed(corner_b[j*C +: C]) - $signed(corner_a[j*C +: C]);
        ad1[j] <= $signed(corner_d[j*C +: C]) - $signed(corner_a[j*C +: C]);
        tv1[j] <= org[j] - $signed(corner_a[j*C +: C]);
        cd1[j] <= $signed(corner_d[j*C +: C]) - $signed(corner_c[j*C +: C]);
        cb1[j] <= $signed(corner_b[j*C +: C]) - $signed(corner_c[j*C +: C]);
        tw1[j] <= org[j] - $signed(corner_c[j*C +: C]);
        dr1[j] <= E'(dir[j]);
      end
    end
  end

  // Stage 2: cross products; the vectors needed later travel along.
  logic signed [X-1:0] pv2 [3];
  logic signed [X-1:0] qv2 [3];
  logic signed [X-1:0] pw2 [3];
  logic signed [X-1:0] qw2 [3];
  logic signed [E-1:0] ab2 [3];
  logic signed [E-1:0] ad2 [3];
  logic signed [E-1:0] tv2 [3];
  logic signed [E-1:0] cd2 [3];
  logic signed [E-1:0] tw2 [3];
  logic signed [E-1:0] dr2 [3];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int i = 0; i < 3; i++) begin
        pv2[i] <= dr1[(i+1)%3] * ad1[(i+2)%3] - dr1[(i+2)%3] * ad1[(i+1)%3];
        qv2[i] <= tv1[(i+1)%3] * ab1[(i+2)%3] - tv1[(i+2)%3] * ab1[(i+1)%3];
        pw2[i] <= dr1[(i+1)%3] * cb1[(i+2)%3] - dr1[(i+2)%3] * cb1[(i+1)%3];
        qw2[i] <= tw1[(i+1)%3] * cd1[(i+2)%3] - tw1[(i+2)%3] * cd1[(i+1)%3];
        ab2[i] <= ab1[i];
        ad2[i] <= ad1[i];
        tv2[i] <= tv1[i];
        cd2[i] <= cd1[i];
        tw2[i] <= tw1[i];
        dr2[i] <= dr1[i];
      end
    end
  end

  // Stage 3: the per-component products of all seven dot products.
  logic signed [PW-1:0] p_dt [3];
  logic signed [PW-1:0] p_na [3];
  logic signed [PW-1:0] p_nb [3];
  logic signed [PW-1:0] p_nt [3];
  logic signed [PW-1:0] p_dt2 [3];
  logic signed [PW-1:0] p_na2 [3];
  logic signed [PW-1:0] p_nb2 [3];

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        p_dt[i]  <= ab2[i] * pv2[i];
        p_na[i]  <= tv2[i] * pv2[i];
        p_nb[i]  <= dr2[i] * qv2[i];
        p_nt[i]  <= ad2[i] * qv2[i];
        p_dt2[i] <= cd2[i] * pw2[i];
        p_na2[i] <= tw2[i] * pw2[i];
        p_nb2[i] <= dr2[i] * qw2[i];
      end
    end
  end

  // Stage 4: sum the products into determinants and numerators.
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      dt  <= p_dt[0] + p_dt[1] + p_dt[2];
      na  <= p_na[0] + p_na[1] + p_na[2];
      nb  <= p_nb[0] + p_nb[1] + p_nb[2];
      nt  <= p_nt[0] + p_nt[1] + p_nt[2];
      dt2 <= p_dt2[0] + p_dt2[1] + p_dt2[2];
      na2 <= p_na2[0] + p_na2[1] + p_na2[2];
      nb2 <= p_nb2[0] + p_nb2[1] + p_nb2[2];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rqi_test.sv
// Sign normalization and the inside/outside decisions of the two-triangle test.
`default_nettype none

module rqi_test #(
  parameter int COORD_BITS = 20
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rqi_pkg::lim_t             lim,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [3*COORD_BITS+5:0] dt,
  input  wire logic signed [3*COORD_BITS+5:0] na,
  input  wire logic signed [3*COORD_BITS+5:0] nb,
  input  wire logic signed [3*COORD_BITS+5:0] nt,
  input  wire logic signed [3*COORD_BITS+5:0] dt2,
  input  wire logic signed [3*COORD_BITS+5:0] na2,
  input  wire logic signed [3*COORD_BITS+5:0] nb2,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           hit,
  output logic [3*COORD_BITS+5:0]        num,
  output logic [3*COORD_BITS+5:0]        den
);

  localparam int DW = 3 * COORD_BITS + 6;
  localparam int LW = rqi_pkg::DIST_BITS;
  localparam int N  = 2;

  // Stage handshake.
  logic [N-1:0] v;
  logic [N-1:0] vin;
  logic [N:0]   rdy;
  logic [N-1:0] ld;

  assign rdy[N] = out_ready;
  assign vin    = {v[N-2:0], in_valid};

  for (genvar i = 0; i < N; i++) begin : g_hs
    assign rdy[i] = !v[i] || rdy[i+1];
    assign ld[i]  = vin[i] && rdy[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (rdy[i]) begin
          v[i] <= vin[i];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[N-1];

  // Stage 1: make each determinant non-negative, flipping its numerators with it.
  logic signed [DW-1:0] dtn, nan, nbn, ntn, dt2n, na2n, nb2n;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      dtn  <= dt[DW-1] ? -dt : dt;
      nan  <= dt[DW-1] ? -na : na;
      nbn  <= dt[DW-1] ? -nb : nb;
      ntn  <= dt[DW-1] ? -nt : nt;
      dt2n <= dt2[DW-1] ? -dt2 : dt2;
      na2n <= dt2[DW-1] ? -na2 : na2;
      nb2n <= dt2[DW-1] ? -nb2 : nb2;
    end
  end

  // Stage 2: range checks on both triangles and on the distance sign.
  logic signed [DW-1:0] lim1;
  logic signed [DW-1:0] lim2;
  logic signed [DW:0]   sab;
  logic                 miss1;
  logic                 miss2;
  logic                 far_side;

  always_comb begin
    lim1     = $signed({{(DW-LW){1'b0}}, lim.first});
    lim2     = $signed({{(DW-LW){1'b0}}, lim.second});
    sab      = nan + nbn;
    miss1    = (dtn == '0) || (dtn < lim1) || nan[DW-1] || (nan > dtn)
               || nbn[DW-1] || (nbn > dtn);
    far_side = sab > dtn;
    miss2    = (dt2n == '0) || (dt2n < lim2) || na2n[DW-1] || nb2n[DW-1];
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      hit <= !(miss1 || (far_side && miss2) || ntn[DW-1]);
      num <= ntn;
      den <= dtn;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rqi_div.sv
// Pipelined restoring divider: one quotient bit per stage, with saturation.
`default_nettype none

module rqi_div #(
  parameter int COORD_BITS = 20,
  parameter int FRAC_BITS  = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       hit_in,
  input  wire logic [3*COORD_BITS+5:0]    num,
  input  wire logic [3*COORD_BITS+5:0]    den,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            hit,
  output logic [rqi_pkg::DIST_BITS-1:0]   distance
);

  localparam int QB = rqi_pkg::DIST_BITS;
  localparam int DW = 3 * COORD_BITS + 6;
  localparam int RW = DW + QB;
  localparam int N  = QB + 1;

  // Stage handshake.
  logic [N-1:0] v;
  logic [N-1:0] vin;
  logic [N:0]   rdy;
  logic [N-1:0] ld;

  assign rdy[N] = out_ready;
  assign vin    = {v[N-2:0], in_valid};

  for (genvar i = 0; i < N; i++) begin : g_hs
    assign rdy[i] = !v[i] || rdy[i+1];
    assign ld[i]  = vin[i] && rdy[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (rdy[i]) begin
          v[i] <= vin[i];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[N-1];

  logic [RW-1:0] rem [0:QB-1];
  logic [DW-1:0] dd  [0:QB-1];
  logic [QB-1:0] q   [0:QB];
  logic          hs  [0:QB];
  logic          sat [0:QB];

  // First stage: scale the numerator and test for a quotient that overflows.
  logic [RW-1:0] rem_init;

  assign rem_init = {{QB{1'b0}}, num} << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      rem[0] <= rem_init;
      dd[0]  <= den;
      q[0]   <= '0;
      hs[0]  <= hit_in;
      sat[0] <= rem_init >= {den, {QB{1'b0}}};
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar i = 1; i <= QB; i++) begin : g_bit
    localparam int K = QB - i;
    logic [RW-1:0] dk;
    logic          take;

    assign dk   = RW'(dd[i-1]) << K;
    assign take = rem[i-1] >= dk;

    always_ff @(posedge clk) begin
      if (ld[i]) begin
        q[i]   <= take ? (q[i-1] | (QB'(1) << K)) : q[i-1];
        hs[i]  <= hs[i-1];
        sat[i] <= sat[i-1];
      end
    end

    if (i < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (ld[i]) begin
          rem[i] <= take ? (rem[i-1] - dk) : rem[i-1];
          dd[i]  <= dd[i-1];
        end
      end
    end
  end

  // Result: zero on a miss, all ones when the distance saturates.
  assign hit      = hs[QB];
  assign distance = !hs[QB] ? '0 : (sat[QB] ? '1 : q[QB]);

endmodule

`default_nettype wire

>>> rtl/ray_quad_intersect.sv
// Top level of the ray/quadrilateral intersection pipeline.
`default_nettype none

// Tests one ray against one planar quad (corners A, B, C, D, with C opposite A)
// per clock: four geometry stages (edge vectors, cross products, dot-product
// terms, sums), two test stages, a 33-stage divider (an overflow test, then one
// quotient bit of the distance per stage) and the output register. A new item
// can be accepted every cycle; a stalled output only holds back stages that are
// already full. The distance is t as unsigned fixed point with FRAC_BITS
// fraction bits, saturated to all ones, and zero on a miss. The user must
// write the two determinant limits through the configuration channel (index 0
// first triangle, index 1 second) only while idle; the block does not check.
module ray_quad_intersect #(
  parameter int COORD_BITS = 20,
  parameter int FRAC_BITS  = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rqi_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [rqi_pkg::DIST_BITS-1:0]    cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [COORD_BITS-1:0]     origin_x,
  input  wire logic signed [COORD_BITS-1:0]     origin_y,
  input  wire logic signed [COORD_BITS-1:0]     origin_z,
  input  wire logic signed [COORD_BITS-1:0]     dir_x,
  input  wire logic signed [COORD_BITS-1:0]     dir_y,
  input  wire logic signed [COORD_BITS-1:0]     dir_z,
  input  wire logic [3*COORD_BITS-1:0]          corner_a,
  input  wire logic [3*COORD_BITS-1:0]          corner_b,
  input  wire logic [3*COORD_BITS-1:0]          corner_c,
  input  wire logic [3*COORD_BITS-1:0]          corner_d,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  hit,
  output logic [rqi_pkg::DIST_BITS-1:0]         distance
);

  localparam int DW = 3 * COORD_BITS + 6;

  // Limit registers; a transfer to an unused index is dropped.
  rqi_pkg::lim_t lim;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim.first  <= rqi_pkg::DIST_BITS'(1);
      lim.second <= rqi_pkg::DIST_BITS'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        rqi_pkg::CFG_DET_FIRST:  lim.first  <= cfg_data;
        rqi_pkg::CFG_DET_SECOND: lim.second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Geometry stages.
  logic g_valid, g_ready;
  logic signed [DW-1:0] dt, na, nb, nt, dt2, na2, nb2;

  rqi_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk, .rst,
    .in_valid, .in_ready,
    .origin_x, .origin_y, .origin_z,
    .dir_x, .dir_y, .dir_z,
    .corner_a, .corner_b, .corner_c, .corner_d,
    .out_valid(g_valid), .out_ready(g_ready),
    .dt, .na, .nb, .nt, .dt2, .na2, .nb2
  );

  // Decision stages.
  logic t_valid, t_ready, t_hit;
  logic [DW-1:0] num, den;

  rqi_test #(.COORD_BITS(COORD_BITS)) u_test (
    .clk, .rst, .lim,
    .in_valid(g_valid), .in_ready(g_ready),
    .dt, .na, .nb, .nt, .dt2, .na2, .nb2,
    .out_valid(t_valid), .out_ready(t_ready),
    .hit(t_hit), .num, .den
  );

  // Distance divider.
  logic d_valid, d_ready, d_hit;
  logic [rqi_pkg::DIST_BITS-1:0] d_dist;

  rqi_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst,
    .in_valid(t_valid), .in_ready(t_ready),
    .hit_in(t_hit), .num, .den,
    .out_valid(d_valid), .out_ready(d_ready),
    .hit(d_hit), .distance(d_dist)
  );

  // Output register.
  assign d_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_ready) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && d_valid) begin
      hit      <= d_hit;
      distance <= d_dist;
    end
  end

`ifndef SYNTHESIS
  // A miss never carries a distance.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> distance == '0)
    else $error("miss result with nonzero distance");

  // Nothing leaves the pipeline in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // A result transferred from the divider lands in the output register.
  a_load: assert property (@(posedge clk) disable iff (rst)
    d_valid && d_ready |=> out_valid && hit == $past(d_hit))
    else $error("output register did not take divider result");
`endif

endmodule

`default_nettype wire
